@@ rtl/adx_pkg.sv @@
// adx_pkg: shared widths, payload types, back-end state codes and config helpers
// for the ADX trend-strength block. No dependencies; imported by every rtl module.
`timescale 1ns / 1ps

package adx_pkg;

    // sizing
    localparam int MAX_PERIODS = 64;
    localparam int PRICE_BITS  = 32;
    localparam int PTR_W       = $clog2(MAX_PERIODS);
    localparam int CNT_W       = $clog2(MAX_PERIODS + 2);
    localparam int SUM_W       = PRICE_BITS + $clog2(MAX_PERIODS);
    localparam int DIFF_W      = PRICE_BITS + 1;

    // register file
    localparam int WIN_W     = 7;
    localparam int ALPHA_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_N_PERIODS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd1;
    localparam logic [WIN_W-1:0]     N_RESET       = 7'd14;
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = 17'd8738;
    localparam logic [ALPHA_W-1:0]   ALPHA_ONE     = 17'd65536;

    // DX scaling: 100 * 65536 = 25 << 18
    localparam int VAL_W      = 23;
    localparam int FRAC_W     = 16;
    localparam int SCALE_SH   = 18;
    localparam int PRE_SH     = VAL_W - SCALE_SH;
    localparam int M_W        = SUM_W + 5;
    localparam int DIV_CNT_W  = $clog2(VAL_W);
    localparam logic [VAL_W-1:0] DX_SCALE = 23'd6553600;

    // EMA product width: signed alpha times signed difference
    localparam int EMA_W = (ALPHA_W + 1) + (VAL_W + 1);
    localparam logic [EMA_W-1:0] ROUND_HALF = EMA_W'(32768);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PRICE_BITS-1:0] tr;
        logic [PRICE_BITS-1:0] pdm;
        logic [PRICE_BITS-1:0] mdm;
    } t_ring;

    typedef struct packed {
        logic  first;
        t_ring moves;
    } t_move;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_READ,
        BK_ADD,
        BK_PREP,
        BK_MUL,
        BK_MUL2,
        BK_DIV,
        BK_EMA_MUL,
        BK_EMA_ADD,
        BK_EMIT
    } t_back_state;

    // window length: zero acts as one, above the ring depth acts as the depth
    function automatic logic [CNT_W-1:0] win_clamp(input logic [WIN_W-1:0] n);
        logic [CNT_W-1:0] w;
        if (n == '0) begin
            w = CNT_W'(1);
        end else if (32'(n) > 32'(MAX_PERIODS)) begin
            w = CNT_W'(MAX_PERIODS);
        end else begin
            w = CNT_W'(n);
        end
        return w;
    endfunction

    function automatic logic [ALPHA_W-1:0] alpha_clamp(input logic [ALPHA_W-1:0] a);
        return (a > ALPHA_ONE) ? ALPHA_ONE : a;
    endfunction

endpackage

@@ rtl/adx_front.sv @@
// adx_front: accepts bars, keeps the previous bar and forms true range, +DM and -DM.
// Depends on adx_pkg.
`timescale 1ns / 1ps

module adx_front import adx_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_bar_valid,
    output logic                  o_bar_ready,
    input  logic                  i_start_of_series,
    input  logic [PRICE_BITS-1:0] i_bar_high,
    input  logic [PRICE_BITS-1:0] i_bar_low,
    input  logic [PRICE_BITS-1:0] i_bar_close,
    output logic                  o_move_valid,
    input  logic                  i_move_ready,
    output t_move                 o_move
);

    logic                   r_have_prev;
    logic                   r_a_valid;
    logic [PRICE_BITS-1:0]  r_prev_high, r_prev_low, r_prev_close;
    logic                   r_a_first;
    logic signed [DIFF_W-1:0] r_hl, r_up, r_down;
    logic [PRICE_BITS-1:0]  r_ahc, r_alc;

    logic                   accept, push;
    logic [DIFF_W-1:0]      d_hc, d_lc;
    logic [PRICE_BITS-1:0]  abs_hc, abs_lc, t1, tr;
    logic                   up_wins, down_wins;

    assign accept      = i_bar_valid && o_bar_ready;
    assign push        = r_a_valid && i_move_ready;
    assign o_bar_ready = !r_a_valid || i_move_ready;

    // distances to the previous close
    always_comb begin
        d_hc   = {1'b0, i_bar_high} - {1'b0, r_prev_close};
        d_lc   = {1'b0, i_bar_low}  - {1'b0, r_prev_close};
        abs_hc = d_hc[PRICE_BITS] ? (r_prev_close - i_bar_high) : d_hc[PRICE_BITS-1:0];
        abs_lc = d_lc[PRICE_BITS] ? (r_prev_close - i_bar_low)  : d_lc[PRICE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_a_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (push) begin
                r_a_valid <= 1'b0;
            end
            if (i_clear) begin
                r_have_prev <= 1'b0;
            end else if (accept) begin
                r_have_prev <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_first    <= i_start_of_series || !r_have_prev;
            r_hl         <= $signed({1'b0, i_bar_high} - {1'b0, i_bar_low});
            r_up         <= $signed({1'b0, i_bar_high} - {1'b0, r_prev_high});
            r_down       <= $signed({1'b0, r_prev_low} - {1'b0, i_bar_low});
            r_ahc        <= abs_hc;
            r_alc        <= abs_lc;
            r_prev_high  <= i_bar_high;
            r_prev_low   <= i_bar_low;
            r_prev_close <= i_bar_close;
        end
    end

    // a negative high-low span never wins the maximum
    always_comb begin
        t1 = (r_hl[PRICE_BITS] || (r_ahc > r_hl[PRICE_BITS-1:0])) ? r_ahc
                                                                  : r_hl[PRICE_BITS-1:0];
        tr = (r_alc > t1) ? r_alc : t1;
        up_wins   = (r_up > r_down) && !r_up[PRICE_BITS] && (r_up != '0);
        down_wins = (r_down > r_up) && !r_down[PRICE_BITS] && (r_down != '0);
    end

    assign o_move_valid    = r_a_valid;
    assign o_move.first    = r_a_first;
    assign o_move.moves.tr  = tr;
    assign o_move.moves.pdm = up_wins ? r_up[PRICE_BITS-1:0] : '0;
    assign o_move.moves.mdm = down_wins ? r_down[PRICE_BITS-1:0] : '0;

endmodule

@@ rtl/adx_queue.sv @@
// adx_queue: short FIFO of classified moves between the front and the back end.
// Depends on adx_pkg.
`timescale 1ns / 1ps

module adx_queue import adx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_valid,
    output logic  o_wr_ready,
    input  t_move i_wr_data,
    output logic  o_rd_valid,
    input  logic  i_rd_ready,
    output t_move o_rd_data
);

    t_move              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               wr, rd;

    assign o_wr_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

@@ rtl/adx_back.sv @@
// adx_back: ring memory, window sums, serial DX divider, EMA and result register.
// Depends on adx_pkg.
`timescale 1ns / 1ps

module adx_back import adx_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CNT_W-1:0]   i_window,
    input  logic [ALPHA_W-1:0] i_alpha,
    input  logic               i_move_valid,
    output logic               o_move_ready,
    input  t_move              i_move,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_result_valid,
    output logic [VAL_W-1:0]   o_dx_value,
    output logic [VAL_W-1:0]   o_adx_value
);

    t_back_state r_state, n_state;

    // ring memory, one word per slot holding all three moves
    t_ring r_ring [MAX_PERIODS];
    t_ring r_rd;

    t_ring                  r_item;
    logic [PTR_W-1:0]       r_slot, r_ptr;
    logic [CNT_W-1:0]       r_bars_seen;
    logic                   r_ema_started;
    logic                   r_res_valid;
    logic                   r_o_valid;
    logic [SUM_W-1:0]       r_range_sum, r_plus_sum, r_minus_sum;
    logic [SUM_W-1:0]       r_total, r_diff, r_rem;
    logic [M_W-1:0]         r_m;
    logic [VAL_W-1:0]       r_bits, r_q, r_ema;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic signed [EMA_W-1:0] r_prod;

    logic                   pop, mem_rd, mem_we, out_load;
    logic [PTR_W-1:0]       slot;
    logic [CNT_W-1:0]       slot_inc, bs_inc;
    logic                   full, valid_next, prep_zero, div_last;
    logic [SUM_W-1:0]       total, diff;
    logic [M_W-1:0]         m25;
    logic                   div_bit, div_ge;
    logic [SUM_W+1:0]       div_trial;
    logic [SUM_W-1:0]       div_rem;
    logic signed [VAL_W:0]  ema_diff;
    logic signed [EMA_W-1:0] ema_sum;

    // window bookkeeping
    always_comb begin
        slot       = ({1'b0, r_ptr} < ($bits(r_ptr) + 1)'(i_window)) ? r_ptr : '0;
        slot_inc   = CNT_W'(r_slot) + CNT_W'(1);
        full       = r_bars_seen > i_window;
        bs_inc     = (r_bars_seen <= i_window) ? r_bars_seen + CNT_W'(1) : r_bars_seen;
        valid_next = bs_inc > i_window;
        total      = r_plus_sum + r_minus_sum;
        diff       = (r_plus_sum > r_minus_sum) ? r_plus_sum - r_minus_sum
                                                : r_minus_sum - r_plus_sum;
        prep_zero  = (r_range_sum == '0) || (total == '0);
        m25        = r_m + M_W'(r_diff);
    end

    // one restoring step per cycle
    always_comb begin
        div_bit   = r_bits[VAL_W-1];
        div_trial = {1'b0, r_rem, div_bit} - {2'b00, r_total};
        div_ge    = !div_trial[SUM_W+1];
        div_rem   = div_ge ? div_trial[SUM_W-1:0] : {r_rem[SUM_W-2:0], div_bit};
        div_last  = (r_cnt == DIV_CNT_W'(VAL_W - 1));
    end

    // ema = ema + alpha * (dx - ema) / 65536, rounded half up
    always_comb begin
        ema_diff = $signed({1'b0, r_q}) - $signed({1'b0, r_ema});
        ema_sum  = $signed({{(EMA_W - VAL_W - FRAC_W){1'b0}}, r_ema, {FRAC_W{1'b0}}})
                 + r_prod + $signed(ROUND_HALF);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_move_valid) begin
                    n_state = i_move.first ? BK_EMIT : BK_READ;
                end
            end
            BK_READ:    n_state = BK_ADD;
            BK_ADD:     n_state = valid_next ? BK_PREP : BK_EMIT;
            BK_PREP:    n_state = prep_zero ? BK_EMA_MUL : BK_MUL;
            BK_MUL:     n_state = BK_MUL2;
            BK_MUL2:    n_state = BK_DIV;
            BK_DIV:     n_state = div_last ? BK_EMA_MUL : BK_DIV;
            BK_EMA_MUL: n_state = r_ema_started ? BK_EMA_ADD : BK_EMIT;
            BK_EMA_ADD: n_state = BK_EMIT;
            BK_EMIT: begin
                if (!r_o_valid || i_res_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default:    n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop      = 1'b0;
        mem_rd   = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        case (r_state)
            BK_IDLE: begin
                pop    = i_move_valid;
                mem_rd = i_move_valid && !i_move.first;
            end
            BK_READ: mem_we   = 1'b1;
            BK_EMIT: out_load = !r_o_valid || i_res_ready;
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    assign o_move_ready = (r_state == BK_IDLE);

    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_rd <= r_ring[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_slot] <= r_item;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_o_valid     <= 1'b0;
            r_bars_seen   <= '0;
            r_ptr         <= '0;
            r_ema_started <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                BK_IDLE: begin
                    if (pop && i_move.first) begin
                        r_bars_seen   <= CNT_W'(1);
                        r_ptr         <= '0;
                        r_ema_started <= 1'b0;
                    end
                end
                BK_ADD: begin
                    r_bars_seen <= bs_inc;
                    r_ptr       <= (slot_inc >= i_window) ? '0 : slot_inc[PTR_W-1:0];
                end
                BK_EMA_MUL: r_ema_started <= 1'b1;
                default: begin
                    r_ema_started <= r_ema_started;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (pop) begin
                    r_item <= i_move.moves;
                    r_slot <= slot;
                    if (i_move.first) begin
                        r_range_sum <= '0;
                        r_plus_sum  <= '0;
                        r_minus_sum <= '0;
                        r_res_valid <= 1'b0;
                    end
                end
            end
            BK_READ: begin
                // drop the entry leaving the window
                if (full) begin
                    r_range_sum <= r_range_sum - SUM_W'(r_rd.tr);
                    r_plus_sum  <= r_plus_sum  - SUM_W'(r_rd.pdm);
                    r_minus_sum <= r_minus_sum - SUM_W'(r_rd.mdm);
                end
            end
            BK_ADD: begin
                r_range_sum <= r_range_sum + SUM_W'(r_item.tr);
                r_plus_sum  <= r_plus_sum  + SUM_W'(r_item.pdm);
                r_minus_sum <= r_minus_sum + SUM_W'(r_item.mdm);
                r_res_valid <= valid_next;
            end
            BK_PREP: begin
                r_total <= total;
                r_diff  <= diff;
                if (prep_zero) begin
                    r_q <= '0;
                end
            end
            BK_MUL: r_m <= M_W'({r_diff, 4'b0000}) + M_W'({r_diff, 3'b000});
            BK_MUL2: begin
                // numerator is 25*diff << 18; its top part is already below the divisor
                r_rem  <= m25[M_W-1:PRE_SH];
                r_bits <= {m25[PRE_SH-1:0], {SCALE_SH{1'b0}}};
                r_cnt  <= '0;
                r_q    <= '0;
            end
            BK_DIV: begin
                r_rem  <= div_rem;
                r_bits <= {r_bits[VAL_W-2:0], 1'b0};
                r_q    <= {r_q[VAL_W-2:0], div_ge};
                r_cnt  <= r_cnt + DIV_CNT_W'(1);
            end
            BK_EMA_MUL: begin
                if (!r_ema_started) begin
                    r_ema <= r_q;
                end
                r_prod <= EMA_W'($signed({1'b0, i_alpha}) * ema_diff);
            end
            BK_EMA_ADD: r_ema <= ema_sum[VAL_W+FRAC_W-1:FRAC_W];
            BK_EMIT: begin
                if (out_load) begin
                    o_result_valid <= r_res_valid;
                    o_dx_value     <= r_res_valid ? r_q : '0;
                    o_adx_value    <= r_res_valid ? r_ema : '0;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_res_valid = r_o_valid;

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (r_rem < r_total))
        else $error("divider remainder not below divisor");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_MUL2) |-> (r_total != '0))
        else $error("divider entered with zero divisor");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_res_valid) |-> ((r_q <= DX_SCALE) && (r_ema <= DX_SCALE)))
        else $error("DX or ADX above full scale");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_res_valid)
        else $error("loaded result not presented");

endmodule

@@ rtl/adx_trend_strength.sv @@
// adx_trend_strength: top level of the ADX trend-strength block; holds the config
// registers and joins adx_front, adx_queue and adx_back. Depends on adx_pkg.
`timescale 1ns / 1ps

// Channel    Direction  Handshake                   Payload
// bar        in         i_bar_valid / o_bar_ready   start_of_series, bar_high/low/close
// result     out        o_res_valid / i_res_ready   result_valid, dx_value, adx_value
// config     in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// A bar whose result is valid and whose sums are nonzero passes through pop, ring
// read, sum update, scaling, the 23-step radix-2 DX divider, the EMA multiply and
// add (the add is skipped for the first DX of a series) and the emit step. Zero-sum
// bars skip the scaling and the divider, bars without a result go from the sum update
// to the emit step, and the first bar of a series goes from pop straight to emit.
// The front stage and a 4-entry queue take new bars while the back end works.
// Reset (synchronous, active low) restores n_periods = 14, alpha = 8738 and
// empties the pipeline; writing n_periods starts a new series.
// A stalled result holds in the output register; the back end waits in its emit step.

module adx_trend_strength import adx_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_bar_valid,
    output logic                  o_bar_ready,
    input  logic                  i_start_of_series,
    input  logic [PRICE_BITS-1:0] i_bar_high,
    input  logic [PRICE_BITS-1:0] i_bar_low,
    input  logic [PRICE_BITS-1:0] i_bar_close,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic                  o_result_valid,
    output logic [VAL_W-1:0]      o_dx_value,
    output logic [VAL_W-1:0]      o_adx_value
);

    logic [WIN_W-1:0]   r_n_periods;
    logic [ALPHA_W-1:0] r_alpha;
    logic               series_clear;
    logic               q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    t_move              q_wr_data, q_rd_data;

    // A new window length invalidates the history: make the next bar start a series.
    assign series_clear = i_cfg_we && (i_cfg_index == CFG_N_PERIODS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_periods <= N_RESET;
            r_alpha     <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_N_PERIODS: r_n_periods <= i_cfg_data[WIN_W-1:0];
                CFG_ALPHA:     r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                default: begin
                    // ignore unknown register indexes
                    r_alpha <= r_alpha;
                end
            endcase
        end
    end

    // Front: hold the previous bar, classify each request into range and moves.
    adx_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_clear           (series_clear),
        .i_bar_valid       (i_bar_valid),
        .o_bar_ready       (o_bar_ready),
        .i_start_of_series (i_start_of_series),
        .i_bar_high        (i_bar_high),
        .i_bar_low         (i_bar_low),
        .i_bar_close       (i_bar_close),
        .o_move_valid      (q_wr_valid),
        .i_move_ready      (q_wr_ready),
        .o_move            (q_wr_data)
    );

    // Queue: let the front run ahead while the divider is busy.
    adx_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (q_wr_valid),
        .o_wr_ready (q_wr_ready),
        .i_wr_data  (q_wr_data),
        .o_rd_valid (q_rd_valid),
        .i_rd_ready (q_rd_ready),
        .o_rd_data  (q_rd_data)
    );

    // Back: advance the window sums, divide, smooth, present the result.
    adx_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window       (win_clamp(r_n_periods)),
        .i_alpha        (alpha_clamp(r_alpha)),
        .i_move_valid   (q_rd_valid),
        .o_move_ready   (q_rd_ready),
        .i_move         (q_rd_data),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_result_valid (o_result_valid),
        .o_dx_value     (o_dx_value),
        .o_adx_value    (o_adx_value)
    );

endmodule
